// ----- hdl/tstf_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tstf_pkg
// Shared types and constants of the tire sensor telegram filter.
// -----------------------------------------------------------------------------
package tstf_pkg;

	localparam int NUM_LEARNED = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	localparam logic [15:0] STAMP_NONE   = 16'hFFFF;
	localparam logic [7:0]  PACKET_RESET = 8'hFF;

	typedef enum logic [1:0] {
		CMD_TELEGRAM = 2'd0,
		CMD_TICK     = 2'd1,
		CMD_SYNC     = 2'd2,
		CMD_CONVERT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ROUTE_NONE       = 2'd0,
		ROUTE_BUFFER     = 2'd1,
		ROUTE_STANDSTILL = 2'd2
	} route_t;

	typedef enum logic [1:0] {
		DROP_NONE      = 2'd0,
		DROP_RANGE     = 2'd1,
		DROP_UNLEARNED = 2'd2,
		DROP_DUPLICATE = 2'd3
	} drop_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEARNED_0 = 3'd0,
		REG_LEARNED_1 = 3'd1,
		REG_LEARNED_2 = 3'd2,
		REG_LEARNED_3 = 3'd3,
		REG_ID_MIN    = 3'd4,
		REG_ID_MAX    = 3'd5,
		REG_MIN_GAP   = 3'd6,
		REG_TRAVEL    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [NUM_LEARNED-1:0][31:0] learned_id;
		logic [7:0]                   id_top_min;
		logic [7:0]                   id_top_max;
		logic [15:0]                  min_gap_ms;
		logic [15:0]                  travel_ms;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] sensor_id;
		logic [7:0]  packet_id;
		logic        developer_mode;
		logic        autolearn_done;
		logic        standstill_active;
		logic [63:0] central_time;
		logic [15:0] wheel_pulse_time;
	} event_t;

endpackage
`default_nettype wire

// ----- hdl/tstf_if.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tstf_if
// Valid/ready channels of the filter: event input and result output.
// -----------------------------------------------------------------------------
interface tstf_event_if import tstf_pkg::*; ();
	logic        valid;
	logic        ready;
	cmd_t        cmd;
	logic [31:0] sensor_id;
	logic [7:0]  packet_id;
	logic        developer_mode;
	logic        autolearn_done;
	logic        standstill_active;
	logic [63:0] central_time;
	logic [15:0] wheel_pulse_time;

	modport source (
		output valid, cmd, sensor_id, packet_id, developer_mode, autolearn_done,
		       standstill_active, central_time, wheel_pulse_time,
		input  ready
	);
	modport sink (
		input  valid, cmd, sensor_id, packet_id, developer_mode, autolearn_done,
		       standstill_active, central_time, wheel_pulse_time,
		output ready
	);
endinterface

interface tstf_result_if import tstf_pkg::*; ();
	logic        valid;
	logic        ready;
	route_t      route;
	drop_t       drop_cause;
	logic [31:0] time_ms;

	modport source (output valid, route, drop_cause, time_ms, input ready);
	modport sink (input valid, route, drop_cause, time_ms, output ready);
endinterface
`default_nettype wire

// ----- hdl/tstf_cfg_regs.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tstf_cfg_regs
// Configuration register file: learned IDs, ID byte range, gap and travel time.
// -----------------------------------------------------------------------------
module tstf_cfg_regs import tstf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   we,
	input  wire logic [CFG_INDEX_W-1:0] index,
	input  wire logic [CFG_DATA_W-1:0]  data,
	output cfg_t                        cfg
);

	cfg_t     cfg_q;
	cfg_idx_t idx;

	assign idx = cfg_idx_t'(index);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learned_id <= '0;
			cfg_q.id_top_min <= 8'd0;
			cfg_q.id_top_max <= 8'hFF;
			cfg_q.min_gap_ms <= 16'd0;
			cfg_q.travel_ms  <= 16'd0;
		end else if (we) begin
			case (idx)
				REG_LEARNED_0: cfg_q.learned_id[0] <= data;
				REG_LEARNED_1: cfg_q.learned_id[1] <= data;
				REG_LEARNED_2: cfg_q.learned_id[2] <= data;
				REG_LEARNED_3: cfg_q.learned_id[3] <= data;
				REG_ID_MIN:    cfg_q.id_top_min    <= data[7:0];
				REG_ID_MAX:    cfg_q.id_top_max    <= data[7:0];
				REG_MIN_GAP:   cfg_q.min_gap_ms    <= data[15:0];
				REG_TRAVEL:    cfg_q.travel_ms     <= data[15:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tstf_timebase.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tstf_timebase
// Millisecond clock, central clock sync and wheel-pulse stamp conversion.
// -----------------------------------------------------------------------------
module tstf_timebase import tstf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  event_t           ev,
	input  wire logic [15:0] travel_ms,
	output logic      [31:0] local_clock,
	output logic      [31:0] time_ms
);

	logic [31:0] local_clock_q;
	logic [63:0] sync_start_q;
	logic [31:0] sync_current_q;
	logic        synced_q;

	logic [31:0] clock_nxt;
	logic [15:0] stamp_hi;
	logic [31:0] stamp_abs;
	logic [31:0] stamp_t;
	logic [31:0] travel_32;
	logic [31:0] conv_t;

	assign local_clock = local_clock_q;
	assign travel_32   = {16'd0, travel_ms};

	always_comb begin
		clock_nxt = local_clock_q;
		case (ev.cmd)
			CMD_TICK: clock_nxt = local_clock_q + 32'd1;
			CMD_SYNC: begin
				if (!synced_q) begin
					clock_nxt = 32'd0;
				end else if (ev.central_time > sync_start_q) begin
					clock_nxt = ev.central_time[31:0] - sync_start_q[31:0];
				end
			end
			default: ;
		endcase
	end

	// Only the low 32 bits of the extended stamp reach the result, so the
	// high part of the central clock never enters the subtraction.
	always_comb begin
		if (ev.wheel_pulse_time < sync_current_q[15:0]) begin
			stamp_hi = sync_current_q[31:16];
		end else begin
			stamp_hi = sync_current_q[31:16] - 16'd1;
		end
		stamp_abs = {stamp_hi, ev.wheel_pulse_time};
		if (!synced_q || ev.wheel_pulse_time == STAMP_NONE) begin
			stamp_t = local_clock_q;
		end else begin
			stamp_t = stamp_abs - sync_start_q[31:0];
		end
		conv_t = (stamp_t > travel_32) ? stamp_t - travel_32 : stamp_t;
	end

	assign time_ms = (ev.cmd == CMD_CONVERT) ? conv_t : clock_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_clock_q  <= 32'd0;
			sync_start_q   <= 64'd0;
			sync_current_q <= 32'd0;
			synced_q       <= 1'b0;
		end else if (fire) begin
			local_clock_q <= clock_nxt;
			if (ev.cmd == CMD_SYNC) begin
				sync_current_q <= ev.central_time[31:0];
				if (!synced_q) begin
					sync_start_q <= ev.central_time;
					synced_q     <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tstf_history.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tstf_history
// Telegram checks and the per-sensor record of last accept time and packet ID.
// -----------------------------------------------------------------------------
module tstf_history import tstf_pkg::*; #(
	parameter int SENSORS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  event_t           ev,
	input  cfg_t             cfg,
	input  wire logic [31:0] now,
	output route_t           route,
	output drop_t            drop_cause
);

	logic [31:0] last_time_q [SENSORS];
	logic [7:0]  last_pkt_q  [SENSORS];

	logic [SENSORS-1:0] sel;
	logic [SENSORS-1:0] fresh_vec;
	logic [7:0]         top;
	logic               in_range;
	logic               check;
	logic               hit;
	logic               fresh;
	logic               update;

	assign top      = ev.sensor_id[31:24];
	assign in_range = (top >= cfg.id_top_min) && (top <= cfg.id_top_max);
	assign check    = !ev.developer_mode && ev.autolearn_done;

	// The lowest wheel position whose learned ID matches wins.
	always_comb begin
		logic        seen;
		logic [31:0] limit;
		seen = 1'b0;
		for (int k = 0; k < SENSORS; k++) begin
			sel[k] = !seen && (cfg.learned_id[k] == ev.sensor_id);
			seen   = seen || sel[k];
			limit  = last_time_q[k] + {16'd0, cfg.min_gap_ms};
			fresh_vec[k] = (now > limit) || (ev.packet_id != last_pkt_q[k]);
		end
	end

	assign hit   = |sel;
	assign fresh = |(sel & fresh_vec);

	always_comb begin
		route      = ROUTE_NONE;
		drop_cause = DROP_NONE;
		update     = 1'b0;
		if (ev.cmd == CMD_TELEGRAM) begin
			if (!in_range) begin
				drop_cause = DROP_RANGE;
			end else if (check && !hit) begin
				drop_cause = DROP_UNLEARNED;
			end else if (check && !fresh) begin
				drop_cause = DROP_DUPLICATE;
			end else begin
				route  = ev.standstill_active ? ROUTE_STANDSTILL : ROUTE_BUFFER;
				update = check;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SENSORS; k++) begin
				last_time_q[k] <= 32'd0;
				last_pkt_q[k]  <= PACKET_RESET;
			end
		end else if (fire && update) begin
			for (int k = 0; k < SENSORS; k++) begin
				if (sel[k]) begin
					last_time_q[k] <= now;
					last_pkt_q[k]  <= ev.packet_id;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tire_sensor_telegram_filter.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// tire_sensor_telegram_filter
// Filters tire pressure sensor telegrams and keeps the local millisecond clock.
// -----------------------------------------------------------------------------
// Every event (telegram, tick, central sync or stamp conversion) gives exactly
// one result. The block takes one event per clock cycle while the result side
// does not stall: an accepted event is held in an input register, and once the
// result register has room the range, learned ID and duplicate checks, the
// clock update and the stamp conversion are all settled in one pass and written
// to the result register together with the clock and sensor history update.
// The result register parts the two sides, so a new event is taken while a
// finished result still waits. Configuration must be written by the user
// through the plain write port only while no event is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
module tire_sensor_telegram_filter import tstf_pkg::*; #(
	parameter int SENSORS = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	tstf_event_if.sink                  events,
	tstf_result_if.source               results
);

	cfg_t        cfg;
	event_t      ev_s1;
	logic        valid_s1;
	logic        out_valid_q;
	route_t      route_q;
	drop_t       drop_q;
	logic [31:0] time_q;

	logic        fire;
	logic        take;
	logic [31:0] local_clock;
	logic [31:0] time_ms;
	route_t      route;
	drop_t       drop_cause;

	assign fire         = valid_s1 && (!out_valid_q || results.ready);
	assign events.ready = !valid_s1 || fire;
	assign take         = events.valid && events.ready;

	tstf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tstf_timebase u_timebase (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.ev          (ev_s1),
		.travel_ms   (cfg.travel_ms),
		.local_clock (local_clock),
		.time_ms     (time_ms)
	);

	tstf_history #(
		.SENSORS (SENSORS)
	) u_history (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.ev         (ev_s1),
		.cfg        (cfg),
		.now        (local_clock),
		.route      (route),
		.drop_cause (drop_cause)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1.cmd               <= events.cmd;
			ev_s1.sensor_id         <= events.sensor_id;
			ev_s1.packet_id         <= events.packet_id;
			ev_s1.developer_mode    <= events.developer_mode;
			ev_s1.autolearn_done    <= events.autolearn_done;
			ev_s1.standstill_active <= events.standstill_active;
			ev_s1.central_time      <= events.central_time;
			ev_s1.wheel_pulse_time  <= events.wheel_pulse_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			route_q <= route;
			drop_q  <= drop_cause;
			time_q  <= time_ms;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.route      = route_q;
	assign results.drop_cause = drop_q;
	assign results.time_ms    = time_q;

`ifndef SYNTHESIS
	// A tick that completes advances the local clock by exactly one.
	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_s1.cmd == CMD_TICK |=> local_clock == $past(local_clock) + 32'd1)
		else $error("tick did not advance the local clock by one");

	// A routed telegram never carries a drop cause.
	a_route_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && route_q != ROUTE_NONE |-> drop_q == DROP_NONE)
		else $error("routed telegram carries a drop cause");

	// The input side stalls only when both the input and result registers are full.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!events.ready |-> valid_s1 && out_valid_q && !results.ready)
		else $error("input stalled while the pipeline had room");

	// Only a telegram may change the routing outcome away from no route.
	a_non_telegram_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ev_s1.cmd != CMD_TELEGRAM |=> route_q == ROUTE_NONE && drop_q == DROP_NONE)
		else $error("non-telegram event produced a route or drop cause");
`endif

endmodule
`default_nettype wire

// ----- sim/telegram_filter_checker.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// telegram_filter_checker
// Watches the event and result channels of the telegram filter, keeps its own
// copy of the filter state and settings, and compares every result transfer
// against the outcome predicted for the oldest event still in flight.
// -----------------------------------------------------------------------------
module telegram_filter_checker import tstf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	tstf_event_if                       events,
	tstf_result_if                      results,
	output int                          errors,
	output int                          pending
);

	typedef struct packed {
		route_t      route;
		drop_t       drop_cause;
		logic [31:0] time_ms;
	} outcome_t;

	cfg_t        settings;
	logic [31:0] clock_ms;
	logic [63:0] sync_origin;
	logic [63:0] sync_latest;
	logic        is_synced;
	logic [31:0] accepted_at [NUM_LEARNED];
	logic [7:0]  last_packet_id [NUM_LEARNED];
	outcome_t    predicted_outcomes [$];
	int          failures;

	task automatic filter_event(input event_t ev, output outcome_t res);
		logic [31:0] window_end;
		logic [63:0] stamp_hi;
		logic [63:0] stamp_abs;
		logic [31:0] stamp_ms;
		int          hit;
		int          k;
		res.route      = ROUTE_NONE;
		res.drop_cause = DROP_NONE;
		stamp_ms       = '0;
		hit            = -1;
		case (ev.cmd)
			CMD_TELEGRAM: begin
				if (ev.sensor_id[31:24] < settings.id_top_min ||
				    ev.sensor_id[31:24] > settings.id_top_max) begin
					res.drop_cause = DROP_RANGE;
				end else begin
					if (!ev.developer_mode && ev.autolearn_done) begin
						// Scan downward so that the lowest matching position wins.
						for (k = NUM_LEARNED - 1; k >= 0; k--) begin
							if (settings.learned_id[k] == ev.sensor_id)
								hit = k;
						end
						if (hit < 0) begin
							res.drop_cause = DROP_UNLEARNED;
						end else begin
							window_end = accepted_at[hit] + 32'(settings.min_gap_ms);
							if (clock_ms > window_end || ev.packet_id != last_packet_id[hit]) begin
								accepted_at[hit]    = clock_ms;
								last_packet_id[hit] = ev.packet_id;
							end else begin
								res.drop_cause = DROP_DUPLICATE;
							end
						end
					end
					if (res.drop_cause == DROP_NONE)
						res.route = ev.standstill_active ? ROUTE_STANDSTILL : ROUTE_BUFFER;
				end
			end
			CMD_TICK: begin
				clock_ms = clock_ms + 32'd1;
			end
			CMD_SYNC: begin
				sync_latest = ev.central_time;
				if (!is_synced) begin
					sync_origin = ev.central_time;
					is_synced   = 1'b1;
					clock_ms    = '0;
				end else if (ev.central_time > sync_origin) begin
					clock_ms = 32'(ev.central_time - sync_origin);
				end
			end
			CMD_CONVERT: begin
				if (!is_synced || ev.wheel_pulse_time == STAMP_NONE) begin
					stamp_ms = clock_ms;
				end else begin
					// A stamp at or above the current low half belongs to the previous period.
					stamp_hi = sync_latest & 64'hFFFF_FFFF_FFFF_0000;
					if (ev.wheel_pulse_time < sync_latest[15:0])
						stamp_abs = stamp_hi | 64'(ev.wheel_pulse_time);
					else
						stamp_abs = (stamp_hi - 64'h1_0000) | 64'(ev.wheel_pulse_time);
					stamp_ms = 32'(stamp_abs - sync_origin);
				end
				if (stamp_ms > 32'(settings.travel_ms))
					stamp_ms = stamp_ms - 32'(settings.travel_ms);
			end
		endcase
		res.time_ms = (ev.cmd == CMD_CONVERT) ? stamp_ms : clock_ms;
	endtask

	always @(posedge clk or negedge arst_n) begin
		event_t   ev;
		outcome_t want;
		int       k;
		if (!arst_n) begin
			settings.learned_id = '0;
			settings.id_top_min = 8'h00;
			settings.id_top_max = 8'hFF;
			settings.min_gap_ms = '0;
			settings.travel_ms  = '0;
			clock_ms            = '0;
			sync_origin         = '0;
			sync_latest         = '0;
			is_synced           = 1'b0;
			for (k = 0; k < NUM_LEARNED; k++) begin
				accepted_at[k]    = '0;
				last_packet_id[k] = PACKET_RESET;
			end
			predicted_outcomes.delete();
			failures = 0;
			pending <= 0;
			errors  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					REG_LEARNED_0, REG_LEARNED_1, REG_LEARNED_2, REG_LEARNED_3:
						settings.learned_id[cfg_index[1:0]] = cfg_data[31:0];
					REG_ID_MIN:  settings.id_top_min = cfg_data[7:0];
					REG_ID_MAX:  settings.id_top_max = cfg_data[7:0];
					REG_MIN_GAP: settings.min_gap_ms = cfg_data[15:0];
					REG_TRAVEL:  settings.travel_ms  = cfg_data[15:0];
				endcase
			end
			if (events.valid && events.ready) begin
				ev.cmd               = events.cmd;
				ev.sensor_id         = events.sensor_id;
				ev.packet_id         = events.packet_id;
				ev.developer_mode    = events.developer_mode;
				ev.autolearn_done    = events.autolearn_done;
				ev.standstill_active = events.standstill_active;
				ev.central_time      = events.central_time;
				ev.wheel_pulse_time  = events.wheel_pulse_time;
				filter_event(ev, want);
				predicted_outcomes.push_back(want);
			end
			if (results.valid && results.ready) begin
				if (predicted_outcomes.size() == 0) begin
					if (failures < 10)
						$display("%0t: result transfer with nothing expected: route %0d drop %0d time %08h",
							$time, results.route, results.drop_cause, results.time_ms);
					failures++;
				end else begin
					want = predicted_outcomes.pop_front();
					if (results.route !== want.route || results.drop_cause !== want.drop_cause ||
					    results.time_ms !== want.time_ms) begin
						if (failures < 10)
							$display("%0t: mismatch: expected route %0d drop %0d time %08h, got route %0d drop %0d time %08h",
								$time, want.route, want.drop_cause, want.time_ms,
								results.route, results.drop_cause, results.time_ms);
						failures++;
					end
				end
			end
			pending <= predicted_outcomes.size();
			errors  <= failures;
		end
	end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// testbench
// Drives the tire sensor telegram filter with a directed sequence of telegrams,
// ticks, syncs and stamp conversions, then with random events under three sets
// of register settings and changing backpressure, and reports the verdict.
// -----------------------------------------------------------------------------
module testbench;
	import tstf_pkg::*;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   sink_ready = 1'b0;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     src_idle_pct   = 0;
	int                     sink_stall_pct = 0;
	int                     errors;
	int                     pending;
	cfg_t                   active_settings;
	logic [63:0]            sync_base = 64'h0000_0001_0002_8000;

	tstf_event_if  events ();
	tstf_result_if results ();

	assign results.ready = sink_ready;

	tire_sensor_telegram_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.events    (events),
		.results   (results)
	);

	telegram_filter_checker filter_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.events    (events),
		.results   (results),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		sink_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	initial begin
		#2000000;
		$display("testbench NOT OK");
		$finish;
	end

	// Every field random, so that unused fields toggle too.
	function automatic event_t noise_event(input cmd_t op);
		event_t ev;
		ev.cmd               = op;
		ev.sensor_id         = $urandom;
		ev.packet_id         = 8'($urandom);
		ev.developer_mode    = 1'($urandom);
		ev.autolearn_done    = 1'($urandom);
		ev.standstill_active = 1'($urandom);
		ev.central_time      = {$urandom, $urandom};
		ev.wheel_pulse_time  = 16'($urandom);
		return ev;
	endfunction

	function automatic event_t random_event();
		event_t      ev;
		int unsigned pick;
		ev   = noise_event(CMD_TICK);
		pick = $urandom_range(99);
		if (pick < 45) begin
			ev.cmd = CMD_TELEGRAM;
			if ($urandom_range(99) < 70)
				ev.sensor_id = active_settings.learned_id[$urandom_range(NUM_LEARNED - 1)];
			// A small set of packet IDs makes duplicates common.
			if ($urandom_range(99) < 60)
				ev.packet_id = 8'($urandom_range(1));
			ev.developer_mode = ($urandom_range(99) < 15);
			ev.autolearn_done = ($urandom_range(99) < 80);
		end else if (pick < 70) begin
			ev.cmd = CMD_TICK;
		end else if (pick < 80) begin
			ev.cmd = CMD_SYNC;
			pick   = $urandom_range(99);
			if (pick < 60)
				ev.central_time = sync_base + 64'($urandom_range(5000));
			else if (pick < 80)
				ev.central_time = sync_base + 64'($urandom);
			else if (pick < 90)
				ev.central_time = sync_base - 64'($urandom_range(1000, 1));
		end else begin
			ev.cmd = CMD_CONVERT;
			if ($urandom_range(99) < 10)
				ev.wheel_pulse_time = STAMP_NONE;
		end
		return ev;
	endfunction

	// Learned IDs fall in the valid range, except the last one.
	function automatic cfg_t phase_settings(input logic [7:0] lo, input logic [7:0] hi,
	                                        input logic [15:0] gap, input logic [15:0] travel);
		cfg_t plan;
		int   k;
		for (k = 0; k < NUM_LEARNED - 1; k++)
			plan.learned_id[k] = {8'($urandom_range(hi, lo)), 24'($urandom)};
		plan.learned_id[NUM_LEARNED - 1] = $urandom;
		plan.id_top_min = lo;
		plan.id_top_max = hi;
		plan.min_gap_ms = gap;
		plan.travel_ms  = travel;
		return plan;
	endfunction

	task automatic send_event(input event_t ev);
		if ($urandom_range(99) < src_idle_pct) begin
			events.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		events.valid             <= 1'b1;
		events.cmd               <= ev.cmd;
		events.sensor_id         <= ev.sensor_id;
		events.packet_id         <= ev.packet_id;
		events.developer_mode    <= ev.developer_mode;
		events.autolearn_done    <= ev.autolearn_done;
		events.standstill_active <= ev.standstill_active;
		events.central_time      <= ev.central_time;
		events.wheel_pulse_time  <= ev.wheel_pulse_time;
		do @(posedge clk); while (!events.ready);
	endtask

	task automatic send_telegram(input logic [31:0] id, input logic [7:0] pkt,
	                             input logic dev, input logic learned, input logic stand);
		event_t ev;
		ev                   = noise_event(CMD_TELEGRAM);
		ev.sensor_id         = id;
		ev.packet_id         = pkt;
		ev.developer_mode    = dev;
		ev.autolearn_done    = learned;
		ev.standstill_active = stand;
		send_event(ev);
	endtask

	task automatic send_tick();
		send_event(noise_event(CMD_TICK));
	endtask

	task automatic send_sync(input logic [63:0] central);
		event_t ev;
		ev              = noise_event(CMD_SYNC);
		ev.central_time = central;
		send_event(ev);
	endtask

	task automatic send_convert(input logic [15:0] stamp);
		event_t ev;
		ev                  = noise_event(CMD_CONVERT);
		ev.wheel_pulse_time = stamp;
		send_event(ev);
	endtask

	// Holds the sender off until every result in flight has been taken.
	task automatic drain();
		events.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic load_settings(input cfg_t plan);
		cfg_idx_t idx;
		drain();
		idx = REG_LEARNED_0;
		repeat (idx.num()) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			case (idx)
				REG_ID_MIN:  cfg_data <= 32'(plan.id_top_min);
				REG_ID_MAX:  cfg_data <= 32'(plan.id_top_max);
				REG_MIN_GAP: cfg_data <= 32'(plan.min_gap_ms);
				REG_TRAVEL:  cfg_data <= 32'(plan.travel_ms);
				default:     cfg_data <= plan.learned_id[idx[1:0]];
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we          <= 1'b0;
		active_settings  = plan;
	endtask

	task automatic run_phase(input cfg_t plan, input int count, input int idle, input int stall);
		load_settings(plan);
		src_idle_pct   = idle;
		sink_stall_pct = stall;
		repeat (count) send_event(random_event());
	endtask

	initial begin
		cfg_t plan;
		events.valid             <= 1'b0;
		events.cmd               <= CMD_TELEGRAM;
		events.sensor_id         <= '0;
		events.packet_id         <= '0;
		events.developer_mode    <= 1'b0;
		events.autolearn_done    <= 1'b0;
		events.standstill_active <= 1'b0;
		events.central_time      <= '0;
		events.wheel_pulse_time  <= '0;
		cfg_we                   <= 1'b0;
		cfg_index                <= REG_LEARNED_0;
		cfg_data                 <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Positions 0 and 2 share an ID; position 3 is all ones.
		plan.learned_id[0] = 32'h10AA_0001;
		plan.learned_id[1] = 32'h20BB_0002;
		plan.learned_id[2] = 32'h10AA_0001;
		plan.learned_id[3] = 32'hFFFF_FFFF;
		plan.id_top_min    = 8'h10;
		plan.id_top_max    = 8'hFF;
		plan.min_gap_ms    = 16'd3;
		plan.travel_ms     = 16'd0;
		load_settings(plan);
		src_idle_pct   = 27;
		sink_stall_pct = 58;

		send_convert(16'h1234);
		send_telegram(32'h0500_0000, 8'h00, 1'b0, 1'b1, 1'b0);
		send_telegram(32'h10AA_0001, 8'h00, 1'b0, 1'b1, 1'b0);
		send_telegram(32'h10AA_0001, 8'h00, 1'b0, 1'b1, 1'b0);
		send_telegram(32'h10AA_0001, 8'h00, 1'b1, 1'b1, 1'b0);
		send_telegram(32'h10AA_0001, 8'h00, 1'b0, 1'b0, 1'b1);
		send_telegram(32'h1234_5678, 8'h00, 1'b0, 1'b1, 1'b0);
		send_tick();
		// The stored packet ID resets to all ones, so this one repeats it.
		send_telegram(32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b1, 1'b1);
		send_sync(sync_base);
		send_sync(sync_base + 64'hFFFF_FFFF);
		send_telegram(32'h20BB_0002, 8'h5A, 1'b0, 1'b1, 1'b0);
		send_tick();
		send_telegram(32'h20BB_0002, 8'h5A, 1'b0, 1'b1, 1'b0);
		// The duplicate window end wrapped to 2; three ticks carry the clock past it.
		send_tick();
		send_tick();
		send_tick();
		send_telegram(32'h20BB_0002, 8'h5A, 1'b0, 1'b1, 1'b1);
		send_sync(64'h0);
		send_convert(16'h0000);
		send_sync(sync_base + 64'h1_2345);
		send_convert(16'h0000);
		send_convert(STAMP_NONE);
		send_convert(16'hFFFE);

		run_phase(phase_settings(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF), 180, 27, 58);
		run_phase(phase_settings(8'h40, 8'hBF, 16'd2, 16'd100), 180, 58, 27);
		run_phase(phase_settings(8'hFF, 8'hFF, 16'd0, 16'd1), 170, 0, 0);

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
